@@ hw/rtl/sm3_pkg.sv @@
// ----------------------------------------------------------------------------
// SM3 package
// Shared constants, types and round functions of the SM3 hash engine.
// ----------------------------------------------------------------------------
package sm3_pkg;

  localparam int unsigned WordWidth = 32;
  localparam int unsigned LenWidth  = 61;

  typedef logic [WordWidth-1:0] word_t;

  localparam logic [1:0] KindByte   = 2'd0;
  localparam logic [1:0] KindLast   = 2'd1;
  localparam logic [1:0] KindFinish = 2'd2;

  // Payload of one input word and of one digest word.
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] byte_value;
  } in_word_t;

  typedef struct packed {
    word_t digest_word;
    logic  word_last;
  } out_word_t;

  localparam word_t IvWord [8] = '{
    32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
    32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E
  };
  localparam word_t TjLow  = 32'h79CC4519;
  localparam word_t TjHigh = 32'h7A879D8A;
  localparam logic [7:0] PadMarker = 8'h80;
  localparam logic [5:0] LenPos    = 6'd56;

  function automatic word_t rotl(input word_t x, input logic [4:0] n);
    logic [63:0] d;
    d = {x, x} << n;
    return d[63:32];
  endfunction

  function automatic word_t perm0(input word_t x);
    return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
  endfunction

  function automatic word_t perm1(input word_t x);
    return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
  endfunction

  // Command from the byte packer to the compression core.
  typedef struct packed {
    logic start;
    logic reset_chain;
  } comp_cmd_t;

endpackage

@@ hw/rtl/sm3_stream_if.sv @@
// ----------------------------------------------------------------------------
// SM3 stream interface
// Valid/ready channel carrying one payload word.
// ----------------------------------------------------------------------------
interface sm3_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ hw/rtl/sm3_compress.sv @@
// ----------------------------------------------------------------------------
// SM3 compression core
// One round per cycle. The 16 loaded message words sit in a small memory and
// are copied into a shift window before the rounds; the window then expands the
// schedule in place. The chain value is kept in registers.
// ----------------------------------------------------------------------------
module sm3_round_core (
  input  logic              clk,
  input  logic              rst,
  input  sm3_pkg::comp_cmd_t cmd,
  // Load port: 16 words fed from the packer during the load phase.
  input  logic              ld_valid,
  input  logic [3:0]        ld_addr,
  input  sm3_pkg::word_t    ld_data,
  output logic              busy,
  output logic              done,
  input  logic [2:0]        cv_sel,
  output sm3_pkg::word_t    cv_word
);
  import sm3_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_PRIME, S_ROUND} state_t;
  state_t state;

  // Loaded message words, w[j] at entry j.
  word_t wmem [16];
  word_t cv [8];
  word_t a, b, c, d, e, f, g, h;
  logic [6:0] rnd;
  // Window kept in registers for the expansion taps.
  word_t win [16];

  word_t tj, a12, ss1, ss2, ff, gg, tt1, tt2, wj, wj4, wnew;
  logic hi;

  always_comb begin
    hi   = rnd[5:0] >= 6'd16;
    tj   = hi ? TjHigh : TjLow;
    wj   = win[0];
    wj4  = win[4];
    a12  = rotl(a, 5'd12);
    ss1  = rotl(a12 + e + rotl(tj, rnd[4:0]), 5'd7);
    ss2  = ss1 ^ a12;
    ff   = hi ? ((a & b) | (a & c) | (b & c)) : (a ^ b ^ c);
    gg   = hi ? ((e & f) | (~e & g)) : (e ^ f ^ g);
    tt1  = ff + d + ss2 + (wj ^ wj4);
    tt2  = gg + h + ss1 + wj;
    wnew = perm1(win[0] ^ win[7] ^ rotl(win[13], 5'd15)) ^ rotl(win[3], 5'd7) ^ win[10];
  end

  always_ff @(posedge clk) begin
    if (ld_valid) wmem[ld_addr] <= ld_data;
  end

  assign busy    = state != S_IDLE;
  assign cv_word = cv[cv_sel];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
      rnd   <= '0;
      for (int i = 0; i < 8; i++) cv[i] <= IvWord[i];
    end else begin
      done <= (state == S_ROUND) && (rnd == 7'd63);
      unique case (state)
        S_IDLE: begin
          if (cmd.reset_chain) begin
            for (int i = 0; i < 8; i++) cv[i] <= IvWord[i];
          end
          if (cmd.start) begin
            state <= S_PRIME;
            rnd   <= '0;
          end
        end
        S_PRIME: begin
          // Copy the loaded window out of memory, one read per cycle.
          win[15] <= wmem[rnd[3:0]];
          for (int i = 0; i < 15; i++) win[i] <= win[i+1];
          if (rnd == 7'd15) begin
            state <= S_ROUND;
            rnd   <= '0;
            {a, b, c, d, e, f, g, h} <= {cv[0], cv[1], cv[2], cv[3],
                                         cv[4], cv[5], cv[6], cv[7]};
          end else begin
            rnd <= rnd + 7'd1;
          end
        end
        S_ROUND: begin
          d <= c; c <= rotl(b, 5'd9); b <= a; a <= tt1;
          h <= g; g <= rotl(f, 5'd19); f <= e; e <= perm0(tt2);
          for (int i = 0; i < 15; i++) win[i] <= win[i+1];
          win[15] <= wnew;
          if (rnd == 7'd63) begin
            state <= S_IDLE;
            rnd   <= '0;
            cv[0] <= cv[0] ^ tt1;      cv[1] <= cv[1] ^ a;
            cv[2] <= cv[2] ^ rotl(b, 5'd9); cv[3] <= cv[3] ^ c;
            cv[4] <= cv[4] ^ perm0(tt2); cv[5] <= cv[5] ^ e;
            cv[6] <= cv[6] ^ rotl(f, 5'd19); cv[7] <= cv[7] ^ g;
          end else begin
            rnd <= rnd + 7'd1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

@@ hw/rtl/sm3_hash_engine.sv @@
// ----------------------------------------------------------------------------
// SM3 hash engine
// Byte-stream SM3 hasher with a block buffer memory and a round core.
// ----------------------------------------------------------------------------
// Usage: bytes enter on the in channel as words of {kind, byte_value}.
// Kind 0 adds a byte, kind 1 adds a last byte and finishes, kind 2 finishes
// with no byte; kind 3 is dropped. After a finish the eight digest words
// leave on the out channel, most significant first, word_last on the eighth.
// Each byte is written into a 64-entry block buffer memory. A full block
// is read back into the core, then the core copies its window and runs 64
// rounds, so after the 64th byte the input is not ready until the block is
// compressed. A finish writes the 64 - fill padding bytes one per cycle and
// compresses; when the marker lands at position 56 or later a second
// padding block follows. The digest words then leave one per cycle while
// the receiver is ready. The input is not ready while a block is padding,
// loading or compressing, or while digest words remain.
// Reset returns the chain to the IV and clears the fill and length
// counters; the buffer holds no reset. A stalled receiver holds the output
// word in place and the block simply waits.
// ----------------------------------------------------------------------------
module sm3_hash_engine (
  input  logic clk,
  input  logic rst,
  sm3_stream_if.sink   in_ch,
  sm3_stream_if.source out_ch
);
  import sm3_pkg::*;

  typedef enum logic [2:0] {
    S_IN, S_PAD, S_LOAD, S_COMP, S_EMIT
  } state_t;
  state_t state;

  logic [7:0] buf_mem [64];
  logic [7:0] rd_data;
  logic [5:0] wr_addr, rd_addr;
  logic [7:0] wr_data;
  logic       wr_en;

  logic [5:0] fill;
  logic [LenWidth-1:0] msg_len;
  logic [63:0] bits;
  logic [7:0] len_byte;
  // finishing: a finish was taken and padding is under way.
  // marker_done: the 0x80 marker has been written.
  // ovf: the marker landed in the length field, so this block carries zeros
  // there and a further block holds the length.
  // final_blk: the block being compressed holds the length.
  logic finishing, marker_done, ovf, final_blk;
  logic [6:0] ldcnt;
  word_t ld_word;
  logic ld_valid;
  logic [3:0] ld_addr;
  logic [2:0] emit;
  comp_cmd_t cmd;
  logic busy, done;
  word_t cv_word;
  logic [1:0] kind;
  logic [7:0] byte_value;

  assign kind       = in_ch.data.kind;
  assign byte_value = in_ch.data.byte_value;
  assign in_ch.ready = (state == S_IN);
  assign bits = {msg_len, 3'b000};
  // Length byte for positions 56 to 63, most significant byte first.
  assign len_byte = 8'(bits >> {~fill[2:0], 3'b000});

  always_ff @(posedge clk) begin
    if (wr_en) buf_mem[wr_addr] <= wr_data;
    if (state == S_LOAD) rd_data <= buf_mem[rd_addr];
  end

  // Buffer write: an accepted byte, or a padding byte at the fill position.
  always_comb begin
    wr_en   = 1'b0;
    wr_data = byte_value;
    if (state == S_IN) begin
      wr_en = in_ch.valid && (kind == KindByte || kind == KindLast);
    end else if (state == S_PAD) begin
      wr_en = 1'b1;
      if (!marker_done) wr_data = PadMarker;
      else if (fill >= LenPos && !ovf) wr_data = len_byte;
      else wr_data = 8'h00;
    end
  end

  assign wr_addr = fill;
  assign rd_addr = ldcnt[5:0];

  sm3_round_core u_core (
    .clk, .rst, .cmd, .ld_valid, .ld_addr, .ld_data(ld_word),
    .busy, .done, .cv_sel(emit), .cv_word
  );

  assign out_ch.valid = (state == S_EMIT);
  assign out_ch.data.digest_word = cv_word;
  assign out_ch.data.word_last   = (emit == 3'd7);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IN; fill <= '0; msg_len <= '0; finishing <= 1'b0;
      marker_done <= 1'b0; ovf <= 1'b0; final_blk <= 1'b0;
      ldcnt <= '0; ld_valid <= 1'b0; emit <= '0; cmd <= '0;
    end else begin
      // Each four bytes read back form one schedule word for the core.
      ld_valid <= (state == S_LOAD) && (ldcnt != 7'd0) && (ldcnt[1:0] == 2'd0);
      cmd.start <= (state == S_LOAD) && (ldcnt == 7'd64);
      cmd.reset_chain <= (state == S_EMIT) && out_ch.ready && (emit == 3'd7);
      unique case (state)
        S_IN: begin
          if (in_ch.valid) begin
            unique case (kind)
              KindByte: begin
                fill <= fill + 6'd1;
                msg_len <= msg_len + LenWidth'(1);
                if (fill == 6'd63) begin
                  state <= S_LOAD;
                  ldcnt <= '0;
                end
              end
              KindLast: begin
                fill <= fill + 6'd1;
                msg_len <= msg_len + LenWidth'(1);
                finishing <= 1'b1;
                marker_done <= 1'b0;
                final_blk <= 1'b0;
                ldcnt <= '0;
                // A byte that completes the block is compressed before padding.
                state <= (fill == 6'd63) ? S_LOAD : S_PAD;
              end
              KindFinish: begin
                finishing <= 1'b1;
                marker_done <= 1'b0;
                final_blk <= 1'b0;
                state <= S_PAD;
              end
              default: begin
              end
            endcase
          end
        end
        S_PAD: begin
          if (!marker_done) begin
            marker_done <= 1'b1;
            if (fill >= LenPos) ovf <= 1'b1;
          end
          if (fill == 6'd63) begin
            final_blk <= marker_done && !ovf;
            state <= S_LOAD;
            ldcnt <= '0;
          end
          fill <= fill + 6'd1;
        end
        S_LOAD: begin
          ldcnt <= ldcnt + 7'd1;
          ld_word <= {ld_word[23:0], rd_data};
          if (ldcnt[1:0] == 2'd0) ld_addr <= ldcnt[5:2] - 4'd1;
          if (ldcnt == 7'd64) state <= S_COMP;
        end
        S_COMP: begin
          if (done) begin
            ovf <= 1'b0;
            if (!finishing) state <= S_IN;
            else if (final_blk) begin
              state <= S_EMIT;
              emit <= '0;
            end else state <= S_PAD;
          end
        end
        S_EMIT: begin
          if (out_ch.ready) begin
            emit <= emit + 3'd1;
            if (emit == 3'd7) begin
              state <= S_IN; msg_len <= '0; finishing <= 1'b0;
            end
          end
        end
        default: state <= S_IN;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_ready_only_in: assert property (@(posedge clk) disable iff (rst)
    in_ch.ready |-> !busy) else $error("input ready while core busy");
  a_last_wraps: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.ready && out_ch.data.word_last) |=> state == S_IN)
    else $error("engine did not return after last word");
  a_no_emit_busy: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> !busy) else $error("emit during compression");
`endif
endmodule

@@ sim/sm3_tb_pkg.sv @@
// ----------------------------------------------------------------------------
// SM3 testbench types
// Payload structs of the input and output channels of the SM3 hash engine.
// ----------------------------------------------------------------------------
package sm3_tb_pkg;
  import sm3_pkg::*;

  typedef in_word_t  byte_item_t;
  typedef out_word_t digest_item_t;

  localparam logic [1:0] KindNone = 2'd3;
endpackage

@@ sim/tb.sv @@
// ----------------------------------------------------------------------------
// SM3 hash engine testbench
// Streams messages of random length and content into the engine, computes
// each digest in a self-contained SM3 model and checks every digest word.
// ----------------------------------------------------------------------------
import sm3_pkg::*;
import sm3_tb_pkg::*;

// Digest model and expected-word store. The model keeps its own chain value,
// block buffer and length counter, mirroring the engine's state.
class sm3_digest_board;
  logic [31:0] chain [8];
  logic [7:0]  blk [64];
  int unsigned fill;
  logic [60:0] msg_len;
  digest_item_t pending_words [$];
  int errors;

  function new();
    errors = 0;
    restart();
  endfunction

  function void restart();
    for (int i = 0; i < 8; i++) chain[i] = IvWord[i];
    fill = 0;
    msg_len = '0;
  endfunction

  function logic [31:0] rl(logic [31:0] x, int n);
    n = n % 32;
    return (n == 0) ? x : ((x << n) | (x >> (32 - n)));
  endfunction

  function void compress();
    logic [31:0] w [68];
    logic [31:0] a, b, c, d, e, f, g, h, tj, a12, ss1, ss2, ff, gg, tt1, tt2;
    for (int j = 0; j < 16; j++)
      w[j] = {blk[4*j], blk[4*j+1], blk[4*j+2], blk[4*j+3]};
    for (int j = 16; j < 68; j++) begin
      tj = w[j-16] ^ w[j-9] ^ rl(w[j-3], 15);
      w[j] = (tj ^ rl(tj, 15) ^ rl(tj, 23)) ^ rl(w[j-13], 7) ^ w[j-6];
    end
    {a, b, c, d, e, f, g, h} = {chain[0], chain[1], chain[2], chain[3],
                                chain[4], chain[5], chain[6], chain[7]};
    for (int j = 0; j < 64; j++) begin
      tj  = (j < 16) ? TjLow : TjHigh;
      a12 = rl(a, 12);
      ss1 = rl(a12 + e + rl(tj, j), 7);
      ss2 = ss1 ^ a12;
      if (j < 16) begin
        ff = a ^ b ^ c;
        gg = e ^ f ^ g;
      end else begin
        ff = (a & b) | (a & c) | (b & c);
        gg = (e & f) | (~e & g);
      end
      tt1 = ff + d + ss2 + (w[j] ^ w[j+4]);
      tt2 = gg + h + ss1 + w[j];
      d = c; c = rl(b, 9); b = a; a = tt1;
      h = g; g = rl(f, 19); f = e; e = tt2 ^ rl(tt2, 9) ^ rl(tt2, 17);
    end
    chain[0] ^= a; chain[1] ^= b; chain[2] ^= c; chain[3] ^= d;
    chain[4] ^= e; chain[5] ^= f; chain[6] ^= g; chain[7] ^= h;
  endfunction

  function void absorb(logic [7:0] v);
    blk[fill] = v;
    fill++;
    msg_len++;
    if (fill == 64) begin
      compress();
      fill = 0;
    end
  endfunction

  // Note one accepted input word.
  function void note_input(byte_item_t it);
    logic [63:0] bits;
    int pos;
    digest_item_t dw;
    if (it.kind == KindNone) return;
    if (it.kind != KindFinish) absorb(it.byte_value);
    if (it.kind == KindByte) return;
    bits = {msg_len, 3'b000};
    pos = fill;
    blk[pos] = PadMarker;
    pos++;
    if (pos > LenPos) begin
      while (pos < 64) begin blk[pos] = 8'h00; pos++; end
      compress();
      pos = 0;
    end
    while (pos < LenPos) begin blk[pos] = 8'h00; pos++; end
    for (int i = 0; i < 8; i++) blk[LenPos + i] = bits[63 - 8*i -: 8];
    compress();
    for (int i = 0; i < 8; i++) begin
      dw.digest_word = chain[i];
      dw.word_last = (i == 7);
      pending_words.push_back(dw);
    end
    restart();
  endfunction

  // Check one accepted digest word against the oldest expectation.
  function void check_word(digest_item_t got);
    digest_item_t exp_w;
    if (pending_words.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected digest word %h last %b",
                                 got.digest_word, got.word_last);
      return;
    end
    exp_w = pending_words.pop_front();
    if (got !== exp_w) begin
      errors++;
      if (errors <= 10)
        $display("digest mismatch: expected %h/%b got %h/%b",
                 exp_w.digest_word, exp_w.word_last, got.digest_word, got.word_last);
    end
  endfunction
endclass

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst = 1'b1;

  sm3_stream_if #(.payload_t(byte_item_t))   in_ch ();
  sm3_stream_if #(.payload_t(digest_item_t)) out_ch ();

  sm3_hash_engine dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  // 4 ns clock.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  sm3_digest_board board = new();

  int unsigned idle_cycles = 0;
  int unsigned words_sent = 0;
  bit hold_receiver = 1'b0;   // Requests a long receiver stall.

  initial begin
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
  end

  // Short gaps are common; now and then a long one.
  function automatic int unsigned gap_len();
    if ($urandom_range(0, 3) == 0) return 0;
    if ($urandom_range(0, 15) == 0) return $urandom_range(20, 200);
    return $urandom_range(1, 3);
  endfunction

  // Offer one word and hold it until the engine takes it. Valid stays
  // high across back-to-back words, so it is never lowered and raised in
  // the same step.
  task automatic send_word(logic [1:0] kind, logic [7:0] value, bit allow_gap);
    int unsigned g;
    g = allow_gap ? gap_len() : 0;
    if (g != 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= '{kind: kind, byte_value: value};
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    words_sent++;
  endtask

  // A whole message of the given length, finished by kind 1 or kind 2.
  task automatic send_message(int unsigned len, bit gaps);
    bit last_carries;
    last_carries = (len != 0) && $urandom_range(0, 1);
    for (int unsigned i = 0; i < len; i++)
      send_word((last_carries && i == len - 1) ? KindLast : KindByte,
                8'($urandom), gaps);
    if (!last_carries) send_word(KindFinish, 8'($urandom), gaps);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (board.pending_words.size() != 0) @(posedge clk);
  endtask

  // Input monitor and scoreboard feed, sampled at the rising edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_ch.valid && in_ch.ready) board.note_input(in_ch.data);
      if (out_ch.valid && out_ch.ready) board.check_word(out_ch.data);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver: random stalls, or a long hold-off on request.
  initial begin
    int unsigned g;
    @(negedge rst);
    forever begin
      if (hold_receiver) begin
        out_ch.ready <= 1'b0;
        repeat (600) @(posedge clk);
        hold_receiver = 1'b0;
      end
      g = ($urandom_range(0, 2) == 0) ? gap_len() : 0;
      if (g != 0) begin
        out_ch.ready <= 1'b0;
        repeat (g) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
    end
  end

  // Watchdog: a long stretch with no word moving on either channel.
  initial begin
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (idle_cycles > 20000) begin
        $display("tb NOT OK");
        $finish;
      end
    end
  end

  // Stimulus.
  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty message, a single byte, byte extremes, kind 3 noise.
    send_word(KindFinish, 8'hFF, 1'b0);
    send_word(KindLast, 8'h00, 1'b0);
    send_word(KindByte, 8'hFF, 1'b0);
    send_word(KindNone, 8'hA5, 1'b0);
    send_word(KindLast, 8'hFF, 1'b0);
    send_word(KindByte, 8'h61, 1'b0);
    send_word(KindByte, 8'h62, 1'b0);
    send_word(KindByte, 8'h63, 1'b0);
    send_word(KindFinish, 8'h00, 1'b0);
    // Sender pause until the engine has delivered every digest word.
    wait_drained();

    // Padding boundaries: 56 bytes push the length into a second block,
    // 64 bytes fill a block exactly before the finish.
    send_message(56, 1'b1);
    hold_receiver = 1'b1;           // Long receiver stall while sending on.
    send_message(64, 1'b0);
    send_message(3, 1'b0);
    wait_drained();

    // Random short messages, with some kind-3 noise.
    while (words_sent < 160) begin
      if ($urandom_range(0, 7) == 0) send_word(KindNone, 8'($urandom), 1'b1);
      else send_message($urandom_range(0, 12), 1'b1);
    end
    wait_drained();
    repeat (400) @(posedge clk);

    if (board.errors == 0 && board.pending_words.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end
endmodule
